### hdl/rpn_pkg.sv
// Package with the command codes, sequencer states and shared types of the RPN calculator.
`timescale 1ns / 1ps
package rpn_pkg;

   localparam int NumVars = 26;
   localparam int VarIdxWidth = 5;
   localparam int DataWidth = 32;

   typedef enum logic [3:0] {
      CMD_PUSH   = 4'd0,
      CMD_ADD    = 4'd1,
      CMD_SUB    = 4'd2,
      CMD_MUL    = 4'd3,
      CMD_DIV    = 4'd4,
      CMD_MOD    = 4'd5,
      CMD_SHOW   = 4'd6,
      CMD_DUP    = 4'd7,
      CMD_SWAP   = 4'd8,
      CMD_CLEAR  = 4'd9,
      CMD_RECALL = 4'd10,
      CMD_ASSIGN = 4'd11
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_B,
      ST_RD_A,
      ST_DIV,
      ST_MUL,
      ST_EXEC,
      ST_WR2,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic        start;
      logic        is_mod;
      logic signed [DataWidth-1:0] a;
      logic signed [DataWidth-1:0] b;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic signed [DataWidth-1:0] result;
   } div_rsp_type;

   function automatic logic signed [DataWidth-1:0] sat64(input logic signed [63:0] v);
      logic signed [DataWidth-1:0] r;
      if (v > 64'sh000000007FFFFFFF)
         r = 32'sh7FFFFFFF;
      else if (v < -64'sh0000000080000000)
         r = 32'sh80000000;
      else
         r = v[DataWidth-1:0];
      return r;
   endfunction

endpackage

### hdl/rpn_divider.sv
// Iterative restoring divider for Q16.16 division and integer modulo, one quotient bit a cycle.
`timescale 1ns / 1ps
module rpn_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  rpn_pkg::div_req_type req,
   output rpn_pkg::div_rsp_type rsp
);

   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        mod_ff, mod_in;
   logic        neg_q_ff, neg_q_in;
   logic        neg_r_ff, neg_r_in;
   logic [47:0] num_ff, num_in;
   logic [31:0] den_ff, den_in;
   logic [32:0] rem_ff, rem_in;
   logic [47:0] quo_ff, quo_in;
   logic        done_ff, done_in;
   logic signed [31:0] res_ff, res_in;

   logic [47:0] abs_num;
   logic [31:0] abs_den;
   logic signed [63:0] a_ext, b_ext, a_int, b_int;
   logic [32:0] trial;
   logic signed [63:0] qs, rs;

   always_comb begin
      a_ext = 64'(req.a);
      b_ext = 64'(req.b);
      a_int = a_ext / 64'sd65536;
      b_int = b_ext / 64'sd65536;
      if (req.is_mod) begin
         abs_num = (a_int < 0) ? 48'(-a_int) : 48'(a_int);
         abs_den = (b_int < 0) ? 32'(-b_int) : 32'(b_int);
      end else begin
         abs_num = (a_ext < 0) ? 48'(-(a_ext <<< 16)) : 48'(a_ext <<< 16);
         abs_den = (b_ext < 0) ? 32'(-b_ext) : 32'(b_ext);
      end
   end

   assign trial = {rem_ff[31:0], num_ff[47]} - {1'b0, den_ff};

   always_comb begin
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      mod_in = mod_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      done_in = 1'b0;
      res_in = res_ff;
      qs = '0;
      rs = '0;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in = 7'd48;
         mod_in = req.is_mod;
         neg_q_in = req.a[31] ^ req.b[31];
         neg_r_in = req.a[31];
         num_in = abs_num;
         den_in = abs_den;
         rem_in = '0;
         quo_in = '0;
      end else if (busy_ff) begin
         if (cnt_ff != 7'd0) begin
            if (!trial[32]) begin
               rem_in = trial;
               quo_in = {quo_ff[46:0], 1'b1};
            end else begin
               rem_in = {rem_ff[31:0], num_ff[47]};
               quo_in = {quo_ff[46:0], 1'b0};
            end
            num_in = {num_ff[46:0], 1'b0};
            cnt_in = cnt_ff - 7'd1;
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
            qs = neg_q_ff ? -64'(quo_ff) : 64'(quo_ff);
            rs = neg_r_ff ? -64'(rem_ff) : 64'(rem_ff);
            if (mod_ff)
               res_in = rpn_pkg::sat64(rs <<< 16);
            else
               res_in = rpn_pkg::sat64(qs);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      mod_ff <= mod_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      res_ff <= res_in;
   end

   assign rsp.done = done_ff;
   assign rsp.result = res_ff;

endmodule

### hdl/rpn_stack_calculator.sv
// Top level of the RPN calculator: stack memory, variable memory and the command sequencer.
//  Channel | Direction | Handshake             | Payload
//  req     | in        | req_valid / req_ready | command, number, var_index
//  rsp     | out       | rsp_valid / rsp_ready | shown_value, shown_valid, four error flags
// One transaction is handled at a time; push, clear and recall go idle, execute, output;
// two-operand commands first read two operands; div and mod wait on the 48-step divider.
// The stack and variable memories have registered read ports.
// After reset all 26 entries of the variable memory are cleared before req_ready rises.
// A stalled response holds the sequencer until it is taken.
`timescale 1ns / 1ps
module rpn_stack_calculator #(
   parameter int STACK_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_command,
   input  logic signed [31:0] req_number,
   input  logic [4:0]  req_var_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_shown_value,
   output logic        rsp_shown_valid,
   output logic        rsp_stack_full,
   output logic        rsp_stack_empty,
   output logic        rsp_zero_divisor,
   output logic        rsp_no_variable
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   rpn_pkg::state_type state_ff, state_in;

   logic [31:0] stack_mem [STACK_DEPTH];
   logic [31:0] var_mem [rpn_pkg::NumVars];
   logic [31:0] stk_rd_ff, var_rd_ff;

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [4:0]    clr_ff;
   logic          clr_busy_ff;
   logic          prev_rec_ff, prev_rec_in;
   logic [4:0]    prev_idx_ff, prev_idx_in;

   logic [3:0]    cmd_ff;
   logic signed [31:0] num_ff;
   logic [4:0]    vidx_ff;
   logic signed [31:0] a_ff, a_in, b_ff, b_in;
   logic          a_ok_ff, a_ok_in;
   logic signed [63:0] prod_ff;

   logic signed [31:0] shown_ff, shown_in;
   logic sv_ff, sv_in, full_ff, full_in, empty_ff, empty_in, zd_ff, zd_in, nv_ff, nv_in;

   logic          st_we;
   logic [AW-1:0] st_waddr, st_raddr;
   logic [31:0]   st_wdata;
   logic          v_we;
   logic [4:0]    v_waddr, v_raddr;
   logic [31:0]   v_wdata;

   logic signed [31:0] w2_ff, w2_in;
   logic          w2_en_ff, w2_en_in;

   rpn_pkg::div_req_type dreq;
   rpn_pkg::div_rsp_type drsp;

   rpn_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   logic accept;
   assign accept = req_valid && req_ready;
   logic [CW-1:0] cnt_m1;
   assign cnt_m1 = cnt_ff - CW'(1);

   always_ff @(posedge clock) begin
      if (st_we)
         stack_mem[st_waddr] <= st_wdata;
      stk_rd_ff <= stack_mem[st_raddr];
      if (v_we)
         var_mem[v_waddr] <= v_wdata;
      var_rd_ff <= var_mem[v_raddr];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rpn_pkg::ST_IDLE:
            if (accept) begin
               if (req_command inside {rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL,
                                       rpn_pkg::CMD_DIV, rpn_pkg::CMD_MOD, rpn_pkg::CMD_SWAP,
                                       rpn_pkg::CMD_ASSIGN})
                  state_in = rpn_pkg::ST_RD_B;
               else if (req_command inside {rpn_pkg::CMD_SHOW, rpn_pkg::CMD_DUP})
                  state_in = rpn_pkg::ST_RD_B;
               else
                  state_in = rpn_pkg::ST_EXEC;
            end
         rpn_pkg::ST_RD_B: begin
            if (cmd_ff inside {rpn_pkg::CMD_SHOW, rpn_pkg::CMD_DUP})
               state_in = rpn_pkg::ST_EXEC;
            else
               state_in = rpn_pkg::ST_RD_A;
         end
         rpn_pkg::ST_RD_A: begin
            if (cmd_ff inside {rpn_pkg::CMD_DIV, rpn_pkg::CMD_MOD})
               state_in = rpn_pkg::ST_DIV;
            else if (cmd_ff == rpn_pkg::CMD_MUL)
               state_in = rpn_pkg::ST_MUL;
            else
               state_in = rpn_pkg::ST_EXEC;
         end
         rpn_pkg::ST_MUL: state_in = rpn_pkg::ST_EXEC;
         rpn_pkg::ST_DIV:
            if (!a_ok_ff || drsp.done)
               state_in = rpn_pkg::ST_EXEC;
         rpn_pkg::ST_EXEC:
            state_in = w2_en_in ? rpn_pkg::ST_WR2 : rpn_pkg::ST_OUT;
         rpn_pkg::ST_WR2: state_in = rpn_pkg::ST_OUT;
         rpn_pkg::ST_OUT:
            if (rsp_ready)
               state_in = rpn_pkg::ST_IDLE;
         default: state_in = rpn_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      prev_rec_in = prev_rec_ff;
      prev_idx_in = prev_idx_ff;
      a_in = a_ff;
      b_in = b_ff;
      a_ok_in = a_ok_ff;
      shown_in = shown_ff;
      sv_in = sv_ff;
      full_in = full_ff;
      empty_in = empty_ff;
      zd_in = zd_ff;
      nv_in = nv_ff;
      w2_in = w2_ff;
      w2_en_in = 1'b0;
      st_we = 1'b0;
      st_waddr = cnt_ff[AW-1:0];
      st_wdata = '0;
      st_raddr = cnt_m1[AW-1:0];
      v_we = clr_busy_ff;
      v_waddr = clr_ff;
      v_wdata = '0;
      v_raddr = req_var_index;
      dreq = '0;
      dreq.a = a_ff;
      dreq.b = b_ff;
      dreq.is_mod = (cmd_ff == rpn_pkg::CMD_MOD);
      case (state_ff)
         rpn_pkg::ST_IDLE: begin
            shown_in = '0;
            sv_in = 1'b0;
            full_in = 1'b0;
            empty_in = 1'b0;
            zd_in = 1'b0;
            nv_in = 1'b0;
         end
         rpn_pkg::ST_RD_B: begin
            if (cnt_ff != '0) begin
               cnt_in = cnt_m1;
               b_in = stk_rd_ff;
            end else begin
               empty_in = 1'b1;
               b_in = '0;
            end
            st_raddr = cnt_m1[AW-1:0] - AW'(1);
         end
         rpn_pkg::ST_RD_A: begin
            a_ok_in = 1'b1;
            if ((cmd_ff == rpn_pkg::CMD_DIV && b_in == 0) ||
                (cmd_ff == rpn_pkg::CMD_MOD && (b_in > -32'sd65536) && (b_in < 32'sd65536))) begin
               zd_in = 1'b1;
               a_ok_in = 1'b0;
            end else if (cmd_ff == rpn_pkg::CMD_ASSIGN &&
                         !(prev_rec_ff && prev_idx_ff < 5'(rpn_pkg::NumVars))) begin
               nv_in = 1'b1;
               a_ok_in = 1'b0;
            end
            if (a_ok_in) begin
               if (cnt_ff != '0) begin
                  cnt_in = cnt_m1;
                  a_in = stk_rd_ff;
               end else begin
                  empty_in = 1'b1;
                  a_in = '0;
               end
            end
            dreq.start = a_ok_in && (cmd_ff == rpn_pkg::CMD_DIV || cmd_ff == rpn_pkg::CMD_MOD);
            dreq.a = a_in;
            dreq.b = b_in;
         end
         rpn_pkg::ST_EXEC: begin
            prev_rec_in = 1'b0;
            case (cmd_ff)
               rpn_pkg::CMD_PUSH: begin
                  st_wdata = num_ff;
                  if (cnt_ff < CW'(STACK_DEPTH)) begin
                     st_we = 1'b1;
                     cnt_in = cnt_ff + CW'(1);
                  end else
                     full_in = 1'b1;
               end
               rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL,
               rpn_pkg::CMD_DIV, rpn_pkg::CMD_MOD: begin
                  if (cmd_ff == rpn_pkg::CMD_ADD)
                     st_wdata = rpn_pkg::sat64(64'(a_ff) + 64'(b_ff));
                  else if (cmd_ff == rpn_pkg::CMD_SUB)
                     st_wdata = rpn_pkg::sat64(64'(a_ff) - 64'(b_ff));
                  else if (cmd_ff == rpn_pkg::CMD_MUL)
                     st_wdata = rpn_pkg::sat64(prod_ff / 64'sd65536);
                  else
                     st_wdata = drsp.result;
                  if (a_ok_ff) begin
                     st_we = 1'b1;
                     cnt_in = cnt_ff + CW'(1);
                  end
               end
               rpn_pkg::CMD_SHOW, rpn_pkg::CMD_DUP: begin
                  st_wdata = b_in;
                  st_we = 1'b1;
                  cnt_in = cnt_ff + CW'(1);
                  if (cmd_ff == rpn_pkg::CMD_SHOW) begin
                     shown_in = b_in;
                     sv_in = 1'b1;
                  end else begin
                     w2_in = b_in;
                     if (cnt_ff + CW'(1) < CW'(STACK_DEPTH))
                        w2_en_in = 1'b1;
                     else
                        full_in = 1'b1;
                  end
               end
               rpn_pkg::CMD_SWAP: begin
                  st_wdata = b_ff;
                  st_we = 1'b1;
                  cnt_in = cnt_ff + CW'(1);
                  w2_in = a_ff;
                  w2_en_in = 1'b1;
               end
               rpn_pkg::CMD_CLEAR: cnt_in = '0;
               rpn_pkg::CMD_RECALL:
                  if (vidx_ff < 5'(rpn_pkg::NumVars)) begin
                     prev_rec_in = 1'b1;
                     prev_idx_in = vidx_ff;
                     st_wdata = var_rd_ff;
                     if (cnt_ff < CW'(STACK_DEPTH)) begin
                        st_we = 1'b1;
                        cnt_in = cnt_ff + CW'(1);
                     end else
                        full_in = 1'b1;
                  end
               rpn_pkg::CMD_ASSIGN:
                  if (a_ok_ff) begin
                     v_we = 1'b1;
                     v_waddr = prev_idx_ff;
                     v_wdata = a_ff;
                  end
               default: ;
            endcase
         end
         rpn_pkg::ST_WR2: begin
            st_wdata = w2_ff;
            st_we = 1'b1;
            cnt_in = cnt_ff + CW'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rpn_pkg::ST_IDLE;
         cnt_ff <= '0;
         prev_rec_ff <= 1'b0;
         prev_idx_ff <= '0;
         clr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         prev_rec_ff <= prev_rec_in;
         prev_idx_ff <= prev_idx_in;
         if (clr_busy_ff) begin
            clr_ff <= clr_ff + 5'd1;
            if (clr_ff == 5'(rpn_pkg::NumVars - 1))
               clr_busy_ff <= 1'b0;
         end
      end
      if (accept) begin
         cmd_ff <= req_command;
         num_ff <= req_number;
         vidx_ff <= req_var_index;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      a_ok_ff <= a_ok_in;
      prod_ff <= 64'(a_ff) * 64'(b_ff);
      shown_ff <= shown_in;
      sv_ff <= sv_in;
      full_ff <= full_in;
      empty_ff <= empty_in;
      zd_ff <= zd_in;
      nv_ff <= nv_in;
      w2_ff <= w2_in;
      w2_en_ff <= w2_en_in;
   end

   assign req_ready = (state_ff == rpn_pkg::ST_IDLE) && !clr_busy_ff;
   assign rsp_valid = (state_ff == rpn_pkg::ST_OUT);
   assign rsp_shown_value = shown_ff;
   assign rsp_shown_valid = sv_ff;
   assign rsp_stack_full = full_ff;
   assign rsp_stack_empty = empty_ff;
   assign rsp_zero_divisor = zd_ff;
   assign rsp_no_variable = nv_ff && !w2_en_ff;

endmodule

### hdl/rpn_checker.sv
// Port-level checker for the RPN calculator, bound to the top level.
`timescale 1ns / 1ps
module rpn_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_shown_valid,
   input logic rsp_zero_divisor,
   input logic rsp_no_variable,
   input logic rsp_stack_full
);

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input taken while a response is pending");

   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid) else $error("response in the cycle after request");

   a_show_excl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_shown_valid) |-> !rsp_zero_divisor && !rsp_no_variable)
      else $error("show carries foreign flags");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_stack_full))
      else $error("stalled response changed");

endmodule

bind rpn_stack_calculator rpn_checker u_rpn_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_shown_valid(rsp_shown_valid),
   .rsp_zero_divisor(rsp_zero_divisor), .rsp_no_variable(rsp_no_variable),
   .rsp_stack_full(rsp_stack_full)
);
